>>> hdl/aft_pkg.sv
// Shared types and constants for the actuator frame transceiver.
// Used by every module in the block; has no dependencies of its own.

package aft_pkg;

    // request kinds, taken from bit 0 of req_type
    localparam logic REQ_CMD = 1'b0;
    localparam logic REQ_RX  = 1'b1;

    // outgoing frame sync bytes
    localparam logic [7:0] TX_SYNC0 = 8'h55;
    localparam logic [7:0] TX_SYNC1 = 8'hAA;

    // expected response header bytes
    localparam logic [7:0] RX_HDR0 = 8'hAA;
    localparam logic [7:0] RX_HDR1 = 8'h55;

    // length byte carries payload length plus this bias
    localparam int LEN_BIAS = 2;

    // frame byte positions ahead of the payload
    localparam int POS_SYNC0   = 0;
    localparam int POS_SYNC1   = 1;
    localparam int POS_LEN     = 2;
    localparam int POS_ID      = 3;
    localparam int POS_CMD     = 4;
    localparam int POS_INDEX   = 5;
    localparam int POS_PAYLOAD = 6;

    // response byte positions
    localparam int RX_POS_HDR0 = 0;
    localparam int RX_POS_HDR1 = 1;
    localparam int RX_POS_ID   = 3;
    localparam int SUM_FIRST   = 2;
    localparam int STAT_FIRST  = 7;
    localparam int STAT_COUNT  = 10;

    // payload byte fields carried by a request
    localparam int PAY_FIELDS = 4;

    // saturated payload length, wide enough for the largest payload limit
    localparam int LEN_W = 4;

    typedef struct packed {
        logic       req_type;
        logic [7:0] cmd_code;
        logic [7:0] reg_index;
        logic [2:0] payload_len;
        logic [7:0] payload_b0;
        logic [7:0] payload_b1;
        logic [7:0] payload_b2;
        logic [7:0] payload_b3;
        logic [7:0] rx_byte;
    } req_t;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        tx_last;
        logic        resp_done;
        logic        resp_ok;
        logic [15:0] goal_pos;
        logic [15:0] actual_pos;
        logic [7:0]  temperature;
        logic [15:0] motor_current;
        logic [15:0] load_force;
        logic [7:0]  fault_bits;
    } rsp_t;

    // classified work item passed from front to back
    typedef struct packed {
        logic                             is_cmd;
        logic [7:0]                       dev_id;
        logic [7:0]                       cmd_code;
        logic [7:0]                       reg_index;
        logic [LEN_W-1:0]                 len;
        logic [PAY_FIELDS-1:0][7:0]       payload;
        logic [7:0]                       csum;
        logic [7:0]                       rx_byte;
    } item_t;

endpackage

>>> hdl/aft_front.sv
// Front end: classifies a request, saturates the payload length and
// precomputes the frame checksum. Depends on aft_pkg.

module aft_front
    import aft_pkg::*;
#(
    parameter int MAX_PAYLOAD = 4
)
(
    input  logic [7:0] device_id,
    input  req_t       req,
    output item_t      item
);

    logic [LEN_W-1:0]           len_sat;
    logic [PAY_FIELDS-1:0][7:0] pay;
    logic [7:0]                 sum;

    assign pay = {req.payload_b3, req.payload_b2, req.payload_b1, req.payload_b0};

    // clip length to the payload limit
    always_comb
    begin
        if ({1'b0, req.payload_len} > LEN_W'(MAX_PAYLOAD))
        begin
            len_sat = LEN_W'(MAX_PAYLOAD);
        end
        else
        begin
            len_sat = {1'b0, req.payload_len};
        end
    end

    // 8-bit sum over length byte through last payload byte
    always_comb
    begin
        sum = 8'(len_sat) + 8'(LEN_BIAS) + device_id + req.cmd_code + req.reg_index;
        for (int i = 0; i < PAY_FIELDS; i++)
        begin
            if (LEN_W'(i) < len_sat)
            begin
                sum = sum + pay[i];
            end
        end
    end

    always_comb
    begin
        item.is_cmd    = (req.req_type == REQ_CMD);
        item.dev_id    = device_id;
        item.cmd_code  = req.cmd_code;
        item.reg_index = req.reg_index;
        item.len       = len_sat;
        item.payload   = pay;
        item.csum      = sum;
        item.rx_byte   = req.rx_byte;
    end

endmodule

>>> hdl/aft_queue.sv
// Two-entry queue decoupling the front end from the back end.
// Depends on aft_pkg for the item type.

module aft_queue
    import aft_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t wr_item,
    input  logic  pop,
    output item_t rd_item,
    output logic  full,
    output logic  not_empty
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t              entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

>>> hdl/aft_back.sv
// Back end: serialises command frames byte by byte and checks response bytes,
// driving the registered result stage. Depends on aft_pkg.

module aft_back
    import aft_pkg::*;
#(
    parameter int MAX_PAYLOAD = 4,
    parameter int RESP_LEN    = 21
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  item_t head,
    input  logic  head_valid,
    output logic  pop,
    output rsp_t  rsp,
    output logic  rsp_valid,
    input  logic  rsp_stall
);

    localparam int POS_W = $clog2(MAX_PAYLOAD + POS_PAYLOAD + 1);
    localparam int CNT_W = $clog2(RESP_LEN + 1);

    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [CNT_W-1:0]  rx_count_reg;
    logic [CNT_W-1:0]  rx_count_next;
    logic [7:0]        rx_sum_reg;
    logic [7:0]        rx_sum_next;
    logic              hdr_match_reg;
    logic              hdr_match_next;
    logic              id_match_reg;
    logic              id_match_next;
    logic [7:0]        status_reg [STAT_COUNT];
    logic [7:0]        status_view [STAT_COUNT];
    rsp_t              rsp_reg;
    rsp_t              rsp_next;
    logic              rsp_valid_reg;

    logic              out_ld;
    logic              fire;
    logic [POS_W-1:0]  last_pos;
    logic              frame_end;
    logic [POS_W-1:0]  pidx;
    logic [7:0]        pay_byte;
    logic [7:0]        tx_byte;
    logic              in_window;
    logic              rx_last;
    logic              has_result;

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    // result stage can take a new transfer
    assign out_ld    = !rsp_valid_reg || !rsp_stall;
    assign fire      = head_valid && out_ld;
    assign last_pos  = POS_W'(head.len) + POS_W'(POS_PAYLOAD);
    assign frame_end = (pos_reg == last_pos);
    assign pop       = fire && (!head.is_cmd || frame_end);

    // payload byte at current position, zero past the carried fields
    assign pidx = pos_reg - POS_W'(POS_PAYLOAD);
    always_comb
    begin
        if (pidx < POS_W'(PAY_FIELDS))
        begin
            pay_byte = head.payload[pidx[1:0]];
        end
        else
        begin
            pay_byte = '0;
        end
    end

    // frame byte selection
    always_comb
    begin
        priority if (pos_reg == POS_W'(POS_SYNC0))
        begin
            tx_byte = TX_SYNC0;
        end
        else if (pos_reg == POS_W'(POS_SYNC1))
        begin
            tx_byte = TX_SYNC1;
        end
        else if (pos_reg == POS_W'(POS_LEN))
        begin
            tx_byte = 8'(head.len) + 8'(LEN_BIAS);
        end
        else if (pos_reg == POS_W'(POS_ID))
        begin
            tx_byte = head.dev_id;
        end
        else if (pos_reg == POS_W'(POS_CMD))
        begin
            tx_byte = head.cmd_code;
        end
        else if (pos_reg == POS_W'(POS_INDEX))
        begin
            tx_byte = head.reg_index;
        end
        else if (frame_end)
        begin
            tx_byte = head.csum;
        end
        else
        begin
            tx_byte = pay_byte;
        end
    end

    // response receiver
    assign in_window = (rx_count_reg < CNT_W'(RESP_LEN));
    assign rx_last   = (rx_count_reg == CNT_W'(RESP_LEN - 1));

    // status bytes with the arriving byte forwarded
    always_comb
    begin
        for (int k = 0; k < STAT_COUNT; k++)
        begin
            if (rx_count_reg == CNT_W'(STAT_FIRST + k))
            begin
                status_view[k] = head.rx_byte;
            end
            else
            begin
                status_view[k] = status_reg[k];
            end
        end
    end

    // next state of sequencer and receiver
    always_comb
    begin
        pos_next       = pos_reg;
        rx_count_next  = rx_count_reg;
        rx_sum_next    = rx_sum_reg;
        hdr_match_next = hdr_match_reg;
        id_match_next  = id_match_reg;
        if (fire && head.is_cmd)
        begin
            if (frame_end)
            begin
                pos_next       = '0;
                rx_count_next  = '0;
                rx_sum_next    = '0;
                hdr_match_next = 1'b1;
                id_match_next  = 1'b0;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
        else if (fire && in_window)
        begin
            if (rx_count_reg == CNT_W'(RX_POS_HDR0) && head.rx_byte != RX_HDR0)
            begin
                hdr_match_next = 1'b0;
            end
            if (rx_count_reg == CNT_W'(RX_POS_HDR1) && head.rx_byte != RX_HDR1)
            begin
                hdr_match_next = 1'b0;
            end
            if (rx_count_reg == CNT_W'(RX_POS_ID))
            begin
                id_match_next = (head.rx_byte == head.dev_id);
            end
            if (!rx_last && rx_count_reg >= CNT_W'(SUM_FIRST))
            begin
                rx_sum_next = rx_sum_reg + head.rx_byte;
            end
            rx_count_next = rx_count_reg + 1'b1;
        end
    end

    // result content
    always_comb
    begin
        rsp_next   = '0;
        has_result = 1'b0;
        if (head.is_cmd)
        begin
            has_result        = fire;
            rsp_next.tx_valid = 1'b1;
            rsp_next.tx_byte  = tx_byte;
            rsp_next.tx_last  = frame_end;
        end
        else
        begin
            has_result             = fire && in_window && rx_last;
            rsp_next.resp_done     = 1'b1;
            rsp_next.resp_ok       = hdr_match_reg && id_match_reg
                                     && (head.rx_byte == rx_sum_reg);
            rsp_next.goal_pos      = {status_view[1], status_view[0]};
            rsp_next.actual_pos    = {status_view[3], status_view[2]};
            rsp_next.temperature   = status_view[4];
            rsp_next.motor_current = {status_view[6], status_view[5]};
            rsp_next.load_force    = {status_view[8], status_view[7]};
            rsp_next.fault_bits    = status_view[9];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            rx_count_reg  <= '0;
            rx_sum_reg    <= '0;
            hdr_match_reg <= 1'b1;
            id_match_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            rx_count_reg  <= rx_count_next;
            rx_sum_reg    <= rx_sum_next;
            hdr_match_reg <= hdr_match_next;
            id_match_reg  <= id_match_next;
            if (has_result)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (has_result)
        begin
            rsp_reg <= rsp_next;
        end
        if (fire && !head.is_cmd && in_window)
        begin
            for (int k = 0; k < STAT_COUNT; k++)
            begin
                if (rx_count_reg == CNT_W'(STAT_FIRST + k))
                begin
                    status_reg[k] <= head.rx_byte;
                end
            end
        end
    end

endmodule

>>> hdl/actuator_frame_transceiver.sv
// Top level of the actuator frame transceiver: front end, queue and back end.
// Depends on aft_pkg, aft_front, aft_queue and aft_back.

// A command request produces its frame as a sequence of result transfers, one
// byte per cycle while no result is stalled: 55 AA, length, device id,
// command, index, payload and the checksum, so payload length plus seven
// bytes (seven to eleven with the default payload limit of four). A
// received-byte request gives a result only on the final response byte,
// carrying the verdict and the status fields. Requests are taken every cycle
// while the two-entry queue between front and back end has room; the frame
// sequencer in the back end sets the sustained rate. The result register is
// refilled in the cycle its transfer is taken, so frame bytes leave back to
// back; while a result is stalled the back end holds. device_id is written
// through the cfg channel, which is always ready.

module actuator_frame_transceiver
    import aft_pkg::*;
#(
    parameter int MAX_PAYLOAD = 4,
    parameter int RESP_LEN    = 21
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  req_t       req,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output rsp_t       rsp,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    logic [7:0] device_id_reg;
    item_t      front_item;
    item_t      head_item;
    logic       q_full;
    logic       q_not_empty;
    logic       q_pop;
    logic       q_push;

    // device id register
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_id_reg <= 8'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            device_id_reg <= cfg_data;
        end
    end

    assign req_stall = q_full;
    assign q_push    = req_valid && !q_full;

    aft_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .device_id (device_id_reg),
        .req       (req),
        .item      (front_item)
    );

    aft_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .wr_item   (front_item),
        .pop       (q_pop),
        .rd_item   (head_item),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    aft_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .RESP_LEN    (RESP_LEN)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head_item),
        .head_valid (q_not_empty),
        .pop        (q_pop),
        .rsp        (rsp),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall)
    );

endmodule
